// ----- design/repeating_period_detector_assert.svh -----
// Assertion macros for the repeating period detector
`ifndef REPEATING_PERIOD_DETECTOR_ASSERT_SVH
`define REPEATING_PERIOD_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define RPD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpd assertion failed");

// Next-cycle implication, disabled while reset is high
`define RPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpd assertion failed");

`endif

// ----- design/rpd_pkg.sv -----
// Package: constants and types for the repeating period detector
package rpd_pkg;

  localparam int MAX_PERIOD = 64;
  localparam int CANDIDATES = MAX_PERIOD - 1;
  localparam int COUNT_W    = $clog2(MAX_PERIOD);
  localparam int PERIOD_W   = 6;
  localparam int LIMIT_W    = 7;
  localparam int BYTE_W     = 8;

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET = LIMIT_W'(64);
  localparam logic [COUNT_W-1:0]  COUNT_MAX   = COUNT_W'(CANDIDATES);

  typedef logic [CANDIDATES-1:0] alive_t;
  typedef logic [BYTE_W-1:0]     byte_t;

endpackage

// ----- design/repeating_period_detector.sv -----
// Top level: smallest repeating period of a byte buffer
//
// Usage:
//   Byte channel: data_byte / last_byte with byte_valid and byte_stall. One
//   word is taken per cycle when byte_valid is high and byte_stall is low.
//   last_byte marks the final word of a buffer.
//   Result channel: period with result_valid and result_stall. One word per
//   buffer, 0 when no period below the limit survived.
//   Config channel: period_limit with cfg_valid and cfg_ready (always ready),
//   written by the user only while the block is idle (not checked). Values
//   above 64 act as 64. A buffer end goes via the middle stage to the result
//   register. Throughput: one byte per cycle while byte_stall is low; all 63
//   candidate compares against the byte history run in parallel, the priority
//   search sits in its own stage. Reset: flags all set, byte count cleared,
//   limit back to 64. Stall: a stalled result holds; a buffer end waits in the
//   middle stage; byte_stall rises only when it is full and cannot drain.
module repeating_period_detector
  import rpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic                last_byte,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [PERIOD_W-1:0] period,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LIMIT_W-1:0]  period_limit
);

  // state
  byte_t                history [CANDIDATES];
  alive_t               alive;
  alive_t               alive_next;
  logic [COUNT_W-1:0]   bytes_seen;
  logic [LIMIT_W-1:0]   limit;
  alive_t               pend_alive;
  logic                 pend_valid;
  logic                 pend_move;
  logic                 out_move;
  logic                 byte_take;
  alive_t               hit;
  logic [PERIOD_W-1:0]  found;

  // handshake control
  assign cfg_ready  = 1'b1;
  assign out_move   = !result_valid || !result_stall;
  assign pend_move  = pend_valid && out_move;
  assign byte_stall = pend_valid && !out_move;
  assign byte_take  = byte_valid && !byte_stall;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= period_limit;
    end
  end

  // parallel compare of the new byte against every candidate distance
  always_comb begin
    for (int i = 0; i < CANDIDATES; i++) begin
      alive_next[i] = alive[i] &&
        !((bytes_seen >= COUNT_W'(i + 1)) && (history[i] != data_byte));
    end
  end

  // byte history shift line, no reset needed: gated by bytes_seen
  always_ff @(posedge clk) begin
    if (byte_take) begin
      history[0] <= data_byte;
      for (int i = 1; i < CANDIDATES; i++) begin
        history[i] <= history[i-1];
      end
    end
  end

  // flags and count, restarted after every buffer end
  always_ff @(posedge clk) begin
    if (rst) begin
      alive      <= '1;
      bytes_seen <= '0;
    end else if (byte_take) begin
      if (last_byte) begin
        alive      <= '1;
        bytes_seen <= '0;
      end else begin
        alive <= alive_next;
        if (bytes_seen != COUNT_MAX) begin
          bytes_seen <= bytes_seen + COUNT_W'(1);
        end
      end
    end
  end

  // middle stage: final flag vector of a finished buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (byte_take && last_byte) begin
      pend_valid <= 1'b1;
    end else if (pend_move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take && last_byte) begin
      pend_alive <= alive_next;
    end
  end

  // smallest surviving period below the limit
  always_comb begin
    found = '0;
    for (int i = 0; i < CANDIDATES; i++) begin
      hit[i] = pend_alive[i] && (LIMIT_W'(i + 1) < limit);
    end
    for (int i = CANDIDATES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found = PERIOD_W'(i + 1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_move) begin
      result_valid <= pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      period <= found;
    end
  end

  // assertions
  `include "repeating_period_detector_assert.svh"

  `RPD_ASSERT_NEXT(a_count_restart, clk, rst, byte_take && last_byte, bytes_seen == '0)
  `RPD_ASSERT_IMPL(a_period_below_limit, clk, rst, result_valid && period != '0,
                   LIMIT_W'(period) < limit)
  `RPD_ASSERT_NEXT(a_end_reaches_pend, clk, rst, byte_take && last_byte, pend_valid)
  `RPD_ASSERT_IMPL(a_stall_only_full, clk, rst, byte_stall, pend_valid && result_valid)

endmodule
